// ===== rtl/deq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the double-ended queue engine.
package deq_pkg;

  localparam int unsigned DefaultDepth = 16;
  localparam int unsigned WordW        = 32;

  // Operation codes carried in the op field of an input item
  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_DUMP       = 3'd4
  } op_e;

  // Status codes of a result item
  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StEmpty = 2'd1;
  localparam logic [1:0] StFull  = 2'd2;

  // Command broadcast to every cell of the chain
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_PUSH_FRONT,
    CMD_PUSH_BACK,
    CMD_POP_FRONT,
    CMD_ROTATE
  } cell_cmd_e;

  typedef struct packed {
    logic [2:0]              op;
    logic signed [WordW-1:0] word_in;
  } in_item_t;

  typedef struct packed {
    logic signed [WordW-1:0] word_out;
    logic [1:0]              status;
    logic                    last;
  } out_item_t;

endpackage

// ===== rtl/deq_cell.sv =====
`timescale 1ns / 1ps
// One storage cell of the queue chain; position IDX counted from the front.
module deq_cell #(
  parameter int unsigned DEPTH = deq_pkg::DefaultDepth,
  parameter int unsigned IDX   = 0
) (
  input  logic                            clk_i,
  input  deq_pkg::cell_cmd_e              cmd_i,
  input  logic [$clog2(DEPTH+1)-1:0]      count_i,
  input  logic signed [deq_pkg::WordW-1:0] word_in_i,
  input  logic signed [deq_pkg::WordW-1:0] left_i,
  input  logic signed [deq_pkg::WordW-1:0] right_i,
  input  logic signed [deq_pkg::WordW-1:0] head_i,
  output logic signed [deq_pkg::WordW-1:0] word_o
);
  import deq_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic signed [WordW-1:0] word_d, word_q;
  logic                    at_count, before_count;

  assign at_count     = (count_i == CntW'(IDX));
  assign before_count = (count_i == CntW'(IDX + 1));

  always_comb begin
    word_d = word_q;
    case (cmd_i)
      CMD_PUSH_FRONT: word_d = (IDX == 0) ? word_in_i : left_i;
      CMD_PUSH_BACK:  if (at_count) word_d = word_in_i;
      CMD_POP_FRONT:  word_d = right_i;
      // back of the occupied run takes the old head, the rest move forward
      CMD_ROTATE:     word_d = before_count ? head_i : right_i;
      default:        word_d = word_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

// ===== rtl/double_ended_queue_engine_core.sv =====
`timescale 1ns / 1ps
// Top level of the double-ended queue engine: control, chain of cells, result register.
//
//  channel | valid       | stall        | payload
//  --------+-------------+--------------+------------------------
//  in      | in_valid_i  | in_stall_o   | in_item_i  (op, word_in)
//  out     | out_valid_o | out_stall_i  | out_item_o (word_out, status, last)
//
// Push and pop codes give one item each, unknown codes none. A dump of n
// stored words gives n items, one item per cycle while the output is not
// stalled, by one rotation step of the cell chain per word; an empty dump
// gives one item. Reset clears the fill count and control only; cells hold
// no reset value and are never read before written. A stalled output item
// holds, and new work waits until the output register is free.
module double_ended_queue_engine_core #(
  parameter int unsigned DEPTH = deq_pkg::DefaultDepth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  deq_pkg::in_item_t    in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output deq_pkg::out_item_t   out_item_o
);
  import deq_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  // occupancy and dump progress
  logic [CntW-1:0] cnt_d, cnt_q;
  logic [CntW-1:0] rem_d, rem_q;
  logic            dump_d, dump_q;

  // result register
  logic            out_valid_d, out_valid_q;
  out_item_t       out_d, out_q;

  cell_cmd_e       cmd;
  logic            accept, slot_free, full, empty;

  logic signed [WordW-1:0] cell_w [DEPTH];

  assign slot_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = dump_q || !slot_free;
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = (cnt_q == CntW'(DEPTH));
  assign empty      = (cnt_q == '0);

  always_comb begin
    cmd         = CMD_HOLD;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    dump_d      = dump_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    if (accept) begin
      case (in_item_i.op)
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          out_valid_d = 1'b1;
          out_d       = '{word_out: '0, status: StOk, last: 1'b1};
          if (full) begin
            out_d.status = StFull;
          end else begin
            cmd   = (in_item_i.op == OP_PUSH_FRONT) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
            cnt_d = cnt_q + 1'b1;
          end
        end
        OP_POP_FRONT, OP_POP_BACK: begin
          out_valid_d = 1'b1;
          out_d       = '{word_out: '0, status: StOk, last: 1'b1};
          if (empty) begin
            out_d.status = StEmpty;
          end else begin
            // pop back only shortens the run; pop front shifts it forward
            cmd   = (in_item_i.op == OP_POP_FRONT) ? CMD_POP_FRONT : CMD_HOLD;
            cnt_d = cnt_q - 1'b1;
          end
        end
        OP_DUMP: begin
          out_valid_d = 1'b1;
          if (empty) begin
            out_d = '{word_out: '0, status: StEmpty, last: 1'b1};
          end else begin
            // first word goes out now; the chain rotates once per word
            cmd    = CMD_ROTATE;
            out_d  = '{word_out: cell_w[0], status: StOk, last: (cnt_q == CntW'(1))};
            rem_d  = cnt_q - 1'b1;
            dump_d = (cnt_q != CntW'(1));
          end
        end
        default: ;  // unknown codes are dropped silently
      endcase
    end else if (dump_q && slot_free) begin
      cmd         = CMD_ROTATE;
      out_valid_d = 1'b1;
      out_d       = '{word_out: cell_w[0], status: StOk, last: (rem_q == CntW'(1))};
      rem_d       = rem_q - 1'b1;
      dump_d      = (rem_q != CntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      rem_q       <= '0;
      dump_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      rem_q       <= rem_d;
      dump_q      <= dump_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // chain of cells, cell 0 is the front of the queue
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [WordW-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = in_item_i.word_in;
    end else begin : g_mid_l
      assign left_w = cell_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_end
      assign right_w = cell_w[0];
    end else begin : g_mid_r
      assign right_w = cell_w[i+1];
    end

    deq_cell #(
      .DEPTH (DEPTH),
      .IDX   (i)
    ) u_cell (
      .clk_i     (clk_i),
      .cmd_i     (cmd),
      .count_i   (cnt_q),
      .word_in_i (in_item_i.word_in),
      .left_i    (left_w),
      .right_i   (right_w),
      .head_i    (cell_w[0]),
      .word_o    (cell_w[i])
    );
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // fill count never passes the depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("fill count beyond depth");

  // during a dump some words remain and fewer than are stored
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dump_q |-> (rem_q != '0) && (rem_q < cnt_q))
    else $error("dump counter out of range");

  // a dump leaves the occupancy untouched
  a_dump_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dump_q |=> cnt_q == $past(cnt_q))
    else $error("fill count changed during dump");

  // error results are single, final and carry no word
  a_err_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status != StOk) |->
      out_item_o.last && (out_item_o.word_out == '0))
    else $error("malformed error item");

endmodule
